### rtl/idlk_pkg.sv
// ============================================================================
// idlk_pkg
// Shared types and constants for the idle, dim and lock controller.
// ============================================================================
`default_nettype none

package idlk_pkg;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int RISE_W   = 12;
    localparam int SPEED_W  = 16;
    localparam int START_W  = 12;
    localparam int DIGIT_W  = 4;
    localparam int LIMIT_W  = 16;
    localparam int CLAMP_W  = LIMIT_W + 1;
    localparam int CODE_W   = 16;
    localparam int ENTRY_W  = 3;
    localparam int CFG_IDX_W = 3;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 16;

    // Default idle counter width
    localparam int COUNT_W_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEAT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWIPE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIGIT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCK  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_PRESENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DIGITS  = 3'd5;

    // Register reset values
    localparam logic [LIMIT_W-1:0] DIM_LIMIT_RST  = 16'd8;
    localparam logic [LIMIT_W-1:0] LOCK_LIMIT_RST = 16'd20;
    localparam logic [LIMIT_W-1:0] OFF_LIMIT_RST  = 16'd120;

    // Swipe acceptance thresholds
    localparam logic [RISE_W-1:0]  SWIPE_MIN_RISE  = 12'd150;
    localparam logic [SPEED_W-1:0] SWIPE_MIN_SPEED = 16'd900;
    localparam logic [START_W-1:0] SWIPE_ZONE      = 12'd200;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX       = 4'd9;
    localparam logic [ENTRY_W-1:0] CODE_LEN        = 3'd4;

    typedef enum logic [1:0] {
        PH_ACTIVE = 2'd0,
        PH_DIMMED = 2'd1,
        PH_LOCKED = 2'd2,
        PH_OFF    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [RISE_W-1:0]  swipe_rise;
        logic [SPEED_W-1:0] swipe_speed;
        logic [START_W-1:0] start_above_bottom;
        logic [DIGIT_W-1:0] digit_value;
    } item_t;

    // Active configuration with limits already clamped
    typedef struct packed {
        logic               enable;
        logic               code_present;
        logic [CODE_W-1:0]  code_digits;
        logic [CLAMP_W-1:0] dim_lim;
        logic [CLAMP_W-1:0] lock_lim;
        logic [CLAMP_W-1:0] off_lim;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic               secure;
        logic               keypad;
        logic [ENTRY_W-1:0] count;
        logic [CODE_W-1:0]  digits;
        logic               mismatch;
    } state_t;

endpackage

`default_nettype wire

### rtl/idle_dim_lock_passcode_fsm_core.sv
// ============================================================================
// idle_dim_lock_passcode_fsm_core
// Idle, dim and lock controller with a four-digit passcode keypad.
// ============================================================================
// Pipeline: two register stages, the input register and then the result
// register; a request's result shows on m_ from the result register.
// Throughput: one request per cycle unless m_tready stalls; the state update
// is a single pass of compare and small add logic between the two registers.
// Reset: aresetn clears the pipeline, the session state and the registers.
`default_nettype none

module idle_dim_lock_passcode_fsm_core #(
    parameter int COUNT_WIDTH = idlk_pkg::COUNT_W_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [idlk_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [idlk_pkg::LIMIT_W-1:0]    cfg_wr_data,
    // Request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [11:0] swipe_rise, [27:12] swipe_speed, [39:28] start_above_bottom,
    // [43:40] digit_value, [47:44] zero
    input  wire logic [idlk_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] command
    input  wire logic [idlk_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] phase_now, [2] secure_session, [3] keypad_shown,
    // [6:4] digits_entered, [7] wrong_code, [8] unlock_pulse, [15:9] zero
    output logic [idlk_pkg::M_TDATA_W-1:0]       m_tdata
);
    import idlk_pkg::*;

    cfg_t                   cfg;
    logic                   clear_req;

    logic                   in_valid_reg;
    item_t                  in_item_reg;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;

    state_t                 state_reg;
    state_t                 state_next;
    logic [COUNT_WIDTH-1:0] idle_reg;
    logic [COUNT_WIDTH-1:0] idle_next;
    logic                   pulse;
    logic                   advance;

    idlk_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (cfg_wr_en),
        .wr_index  (cfg_wr_index),
        .wr_data   (cfg_wr_data),
        .cfg       (cfg),
        .clear_req (clear_req)
    );

    idlk_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .st        (state_reg),
        .idle      (idle_reg),
        .item      (in_item_reg),
        .cfg       (cfg),
        .st_next   (state_next),
        .idle_next (idle_next),
        .pulse     (pulse)
    );

    // Move a request from the input register into the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Capture incoming requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command            <= s_tuser[CMD_W-1:0];
            in_item_reg.swipe_rise         <= s_tdata[11:0];
            in_item_reg.swipe_speed        <= s_tdata[27:12];
            in_item_reg.start_above_bottom <= s_tdata[39:28];
            in_item_reg.digit_value        <= s_tdata[43:40];
        end
    end

    // Hold session state; an enable toggle clears it
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_req) begin
            state_reg <= '{phase: PH_ACTIVE, default: '0};
            idle_reg  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            idle_reg  <= idle_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {7'd0, pulse, state_next.mismatch, state_next.count,
                             state_next.keypad, state_next.secure, state_next.phase};
        end
    end

    // Keypad is only ever up inside a locked session
    a_keypad_secure: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.keypad |-> state_reg.secure)
        else $error("keypad shown outside a locked session");

    // Entry buffer drops back to empty on the fourth digit
    a_entry_short: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count < CODE_LEN)
        else $error("entry count reached code length");

    // Disabled block rests in an unlocked active session
    a_disabled_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg.enable |-> (state_reg.phase == PH_ACTIVE && !state_reg.secure))
        else $error("disabled block left the active phase");

    // An unlock result reports an unlocked active session
    a_unlock_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[1:0] == PH_ACTIVE && !m_tdata[2]))
        else $error("unlock result with session still secure");

    // A request moved on updates the result register
    a_advance_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result lost after advance");

endmodule

`default_nettype wire

### rtl/idlk_cfg.sv
// ============================================================================
// idlk_cfg
// Configuration registers and clamping of the dim, lock and off limits.
// ============================================================================
`default_nettype none

module idlk_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_en,
    input  wire logic [idlk_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [idlk_pkg::LIMIT_W-1:0]    wr_data,
    output idlk_pkg::cfg_t                       cfg,
    output logic                                 clear_req
);
    import idlk_pkg::*;

    logic               enable_reg;
    logic               code_present_reg;
    logic [CODE_W-1:0]  code_digits_reg;
    logic [LIMIT_W-1:0] dim_reg;
    logic [LIMIT_W-1:0] lock_reg;
    logic [LIMIT_W-1:0] off_reg;

    logic [CLAMP_W-1:0] dim_c;
    logic [CLAMP_W-1:0] lock_c;
    logic [CLAMP_W-1:0] off_c;

    // Hold register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            code_present_reg <= 1'b0;
            code_digits_reg  <= '0;
            dim_reg          <= DIM_LIMIT_RST;
            lock_reg         <= LOCK_LIMIT_RST;
            off_reg          <= OFF_LIMIT_RST;
        end else if (wr_en) begin
            case (wr_index)
                REG_LOCK_ENABLE:  enable_reg       <= wr_data[0];
                REG_DIM_LIMIT:    dim_reg          <= wr_data;
                REG_LOCK_LIMIT:   lock_reg         <= wr_data;
                REG_OFF_LIMIT:    off_reg          <= wr_data;
                REG_CODE_PRESENT: code_present_reg <= wr_data[0];
                REG_CODE_DIGITS:  code_digits_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    // Toggling the enable wipes the session state
    assign clear_req = wr_en && (wr_index == REG_LOCK_ENABLE) && (wr_data[0] != enable_reg);

    // Force strictly increasing limits
    always_comb begin
        dim_c  = (dim_reg == '0) ? CLAMP_W'(1) : {1'b0, dim_reg};
        lock_c = ({1'b0, lock_reg} > dim_c) ? {1'b0, lock_reg} : dim_c + CLAMP_W'(1);
        off_c  = ({1'b0, off_reg} > lock_c) ? {1'b0, off_reg} : lock_c + CLAMP_W'(1);
    end

    always_comb begin
        cfg.enable       = enable_reg;
        cfg.code_present = code_present_reg;
        cfg.code_digits  = code_digits_reg;
        cfg.dim_lim      = dim_c;
        cfg.lock_lim     = lock_c;
        cfg.off_lim      = off_c;
    end

endmodule

`default_nettype wire

### rtl/idlk_step.sv
// ============================================================================
// idlk_step
// Next-state logic for one request: phase changes, swipe and keypad handling.
// ============================================================================
`default_nettype none

module idlk_step #(
    parameter int COUNT_WIDTH = idlk_pkg::COUNT_W_DEF
) (
    input  wire idlk_pkg::state_t       st,
    input  wire logic [COUNT_WIDTH-1:0] idle,
    input  wire idlk_pkg::item_t        item,
    input  wire idlk_pkg::cfg_t         cfg,
    output idlk_pkg::state_t         st_next,
    output logic [COUNT_WIDTH-1:0]   idle_next,
    output logic                     pulse
);
    import idlk_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CLAMP_W) ? COUNT_WIDTH : CLAMP_W;

    logic [COUNT_WIDTH-1:0] idle_inc;
    logic [CMP_W-1:0]       idle_cmp;
    logic                   swipe_ok;
    logic                   locked_view;
    logic [CODE_W-1:0]      digits_app;
    logic [ENTRY_W-1:0]     count_app;

    // Saturating increment and compare operand
    always_comb begin
        idle_inc = (&idle) ? idle : idle + COUNT_WIDTH'(1);
        idle_cmp = CMP_W'(idle_inc);
    end

    // Swipe gesture and keypad entry terms
    always_comb begin
        swipe_ok    = (item.start_above_bottom <= SWIPE_ZONE) &&
                      ((item.swipe_rise > SWIPE_MIN_RISE) ||
                       (item.swipe_speed > SWIPE_MIN_SPEED));
        locked_view = st.secure && (st.phase == PH_LOCKED);
        if (st.count < CODE_LEN) begin
            digits_app = {st.digits[CODE_W-DIGIT_W-1:0], item.digit_value};
            count_app  = st.count + ENTRY_W'(1);
        end else begin
            digits_app = st.digits;
            count_app  = st.count;
        end
    end

    always_comb begin
        st_next   = st;
        idle_next = idle;
        pulse     = 1'b0;
        if (cfg.enable) begin
            case (item.command)
                CMD_TICK: begin
                    idle_next = idle_inc;
                    if (!st.secure) begin
                        if (idle_cmp >= CMP_W'(cfg.lock_lim)) begin
                            st_next.secure   = 1'b1;
                            st_next.phase    = PH_LOCKED;
                            st_next.keypad   = 1'b0;
                            st_next.count    = '0;
                            st_next.digits   = '0;
                            st_next.mismatch = 1'b0;
                        end else if (idle_cmp >= CMP_W'(cfg.dim_lim) &&
                                     st.phase == PH_ACTIVE) begin
                            st_next.phase = PH_DIMMED;
                        end
                    end else if (idle_cmp >= CMP_W'(cfg.off_lim) && st.phase == PH_LOCKED) begin
                        st_next.phase = PH_OFF;
                    end
                end
                CMD_SEAT, CMD_SWIPE, CMD_DIGIT: begin
                    // Seat activity wakes the screen first
                    idle_next = '0;
                    if (!st.secure) begin
                        st_next.phase = PH_ACTIVE;
                    end else if (st.phase == PH_OFF) begin
                        st_next.phase  = PH_LOCKED;
                        st_next.keypad = 1'b0;
                        st_next.count  = '0;
                        st_next.digits = '0;
                    end
                    if (item.command == CMD_SWIPE && locked_view && !st.keypad) begin
                        if (swipe_ok) begin
                            if (cfg.code_present) begin
                                st_next.keypad   = 1'b1;
                                st_next.count    = '0;
                                st_next.digits   = '0;
                                st_next.mismatch = 1'b0;
                            end else begin
                                st_next.secure   = 1'b0;
                                st_next.phase    = PH_ACTIVE;
                                st_next.keypad   = 1'b0;
                                st_next.count    = '0;
                                st_next.digits   = '0;
                                st_next.mismatch = 1'b0;
                                pulse            = 1'b1;
                            end
                        end
                    end else if (item.command == CMD_DIGIT && locked_view && st.keypad &&
                                 item.digit_value <= DIGIT_MAX) begin
                        st_next.digits = digits_app;
                        st_next.count  = count_app;
                        if (st.count < CODE_LEN) begin
                            st_next.mismatch = 1'b0;
                        end
                        // Full code typed: compare all four digits
                        if (count_app >= CODE_LEN) begin
                            if (digits_app == cfg.code_digits) begin
                                st_next.secure   = 1'b0;
                                st_next.phase    = PH_ACTIVE;
                                st_next.keypad   = 1'b0;
                                st_next.count    = '0;
                                st_next.digits   = '0;
                                st_next.mismatch = 1'b0;
                                idle_next        = '0;
                                pulse            = 1'b1;
                            end else begin
                                st_next.mismatch = 1'b1;
                                st_next.count    = '0;
                                st_next.digits   = '0;
                            end
                        end
                    end
                end
                CMD_LOCK: begin
                    if (!st.secure) begin
                        st_next.secure   = 1'b1;
                        st_next.phase    = PH_LOCKED;
                        st_next.keypad   = 1'b0;
                        st_next.count    = '0;
                        st_next.digits   = '0;
                        st_next.mismatch = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire
